// File: rtl/text_console_cell_buffer_defines.svh
// ----------------------------------------------------------------------------
// Text console cell buffer assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_CELL_BUFFER_DEFINES_SVH
`define TEXT_CONSOLE_CELL_BUFFER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TCCB_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TCCB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/tccb_pkg.sv
// ----------------------------------------------------------------------------
// Text console cell buffer package
// Shared constants, event codes, controller states and command structs.
// ----------------------------------------------------------------------------
`default_nettype none

package tccb_pkg;

    localparam int ROWS_DEF    = 25;
    localparam int COLS_DEF    = 80;

    localparam int CHAR_W      = 8;
    localparam int ROW_FIELD_W = 5;
    localparam int COL_FIELD_W = 7;
    localparam int EV_W        = 3;
    localparam int S_TDATA_W   = 24;
    localparam int M_TDATA_W   = 32;

    localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;
    localparam logic [CHAR_W-1:0] NUL_CODE     = 8'd0;

    typedef enum logic [EV_W-1:0] {
        EV_IGNORED  = 3'd0,
        EV_STORED   = 3'd1,
        EV_NEWLINE  = 3'd2,
        EV_SCROLLED = 3'd3,
        EV_READ     = 3'd4
    } event_t;

    typedef enum logic [2:0] {
        ST_INIT_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_READ_WAIT,
        ST_SCROLL_CLEAR
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic cap_in;
        logic do_put;
        logic rd_issue;
        logic load_rd;
        logic clr_init;
        logic clr_scroll;
    } tccb_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_read;
        logic is_scroll;
        logic init_last;
        logic scroll_last;
    } tccb_stat_t;

endpackage

`default_nettype wire

// File: rtl/tccb_datapath.sv
// ----------------------------------------------------------------------------
// Text console cell buffer datapath
// Item registers, cursor, circular row origin, cell memory and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module tccb_datapath import tccb_pkg::*; #(
    parameter int ROWS = ROWS_DEF,
    parameter int COLS = COLS_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    input  wire logic                 s_tuser,
    output logic      [M_TDATA_W-1:0] m_tdata,
    output logic      [EV_W-1:0]      m_tuser,
    input  wire tccb_cmd_t            cmd,
    output tccb_stat_t                stat
);

    localparam int RW    = $clog2(ROWS);
    localparam int CW    = $clog2(COLS);
    localparam int DEPTH = ROWS * COLS;
    localparam int AW    = $clog2(DEPTH);

    // Logical row r lives in physical row (top + r) mod ROWS.
    function automatic logic [RW-1:0] phys_row(input logic [RW-1:0] r,
                                               input logic [RW-1:0] t);
        logic [RW:0] s;
        s = {1'b0, r} + {1'b0, t};
        if (s >= (RW+1)'(ROWS))
        begin
            s = s - (RW+1)'(ROWS);
        end
        return s[RW-1:0];
    endfunction

    function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] r,
                                                input logic [CW-1:0] c);
        return AW'(r) * AW'(COLS) + AW'(c);
    endfunction

    // Item registers.
    logic                   cmd_reg;
    logic [CHAR_W-1:0]      char_reg;
    logic [ROW_FIELD_W-1:0] rrow_reg;
    logic [COL_FIELD_W-1:0] rcol_reg;

    // Cursor and scroll state.
    logic [RW-1:0] crow_reg, crow_next;
    logic [CW-1:0] ccol_reg, ccol_next;
    logic [RW-1:0] top_reg, top_next;
    logic [RW-1:0] clr_row_reg;
    logic [AW-1:0] init_cnt_reg;
    logic [CW-1:0] scol_cnt_reg;
    logic          rd_ok_reg;

    // Result register.
    event_t                 out_ev_reg;
    logic [ROW_FIELD_W-1:0] out_row_reg;
    logic [COL_FIELD_W-1:0] out_col_reg;
    logic [CHAR_W-1:0]      out_char_reg;
    logic [ROW_FIELD_W-1:0] out_crow_reg;
    logic [COL_FIELD_W-1:0] out_ccol_reg;

    // Cell memory.
    logic [CHAR_W-1:0] mem [DEPTH];
    logic [CHAR_W-1:0] mem_rdata_reg;
    logic              mem_we;
    logic              mem_re;
    logic [AW-1:0]     mem_addr;
    logic [CHAR_W-1:0] mem_wdata;

    event_t put_kind;
    logic   rd_ok;

    always_comb
    begin
        put_kind = EV_IGNORED;
        if (char_reg == NEWLINE_CODE)
        begin
            put_kind = (crow_reg == RW'(ROWS - 1)) ? EV_SCROLLED : EV_NEWLINE;
        end
        else if (char_reg != NUL_CODE && ccol_reg != CW'(COLS - 1))
        begin
            put_kind = EV_STORED;
        end
    end

    assign rd_ok = (int'(rrow_reg) < ROWS) && (int'(rcol_reg) < COLS);

    always_comb
    begin
        crow_next = crow_reg;
        ccol_next = ccol_reg;
        top_next  = top_reg;
        case (put_kind)
            EV_STORED:
            begin
                ccol_next = ccol_reg + CW'(1);
            end
            EV_NEWLINE:
            begin
                crow_next = crow_reg + RW'(1);
                ccol_next = '0;
            end
            EV_SCROLLED:
            begin
                ccol_next = '0;
                top_next  = (top_reg == RW'(ROWS - 1)) ? '0 : top_reg + RW'(1);
            end
            default:
            begin
                crow_next = crow_reg;
            end
        endcase
    end

    always_comb
    begin
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        mem_wdata = '0;
        mem_addr  = cell_addr(phys_row(RW'(rrow_reg), top_reg), CW'(rcol_reg));
        if (cmd.clr_init)
        begin
            mem_we   = 1'b1;
            mem_addr = init_cnt_reg;
        end
        else if (cmd.clr_scroll)
        begin
            mem_we   = 1'b1;
            mem_addr = cell_addr(clr_row_reg, scol_cnt_reg);
        end
        else if (cmd.do_put)
        begin
            mem_we    = (put_kind == EV_STORED);
            mem_wdata = char_reg;
            mem_addr  = cell_addr(phys_row(crow_reg, top_reg), ccol_reg);
        end
        else
        begin
            mem_re = cmd.rd_issue && rd_ok;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= mem_wdata;
        end
        if (mem_re)
        begin
            mem_rdata_reg <= mem[mem_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crow_reg     <= '0;
            ccol_reg     <= '0;
            top_reg      <= '0;
            clr_row_reg  <= '0;
            init_cnt_reg <= '0;
            scol_cnt_reg <= '0;
        end
        else
        begin
            if (cmd.clr_init)
            begin
                init_cnt_reg <= init_cnt_reg + AW'(1);
            end
            if (cmd.clr_scroll)
            begin
                scol_cnt_reg <= scol_cnt_reg + CW'(1);
            end
            if (cmd.do_put)
            begin
                crow_reg <= crow_next;
                ccol_reg <= ccol_next;
                top_reg  <= top_next;
                if (put_kind == EV_SCROLLED)
                begin
                    // The old top row becomes the new bottom row and is blanked.
                    clr_row_reg  <= top_reg;
                    scol_cnt_reg <= '0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.cap_in)
        begin
            cmd_reg  <= s_tuser;
            char_reg <= s_tdata[7:0];
            rrow_reg <= s_tdata[12:8];
            rcol_reg <= s_tdata[19:13];
        end
        if (cmd.rd_issue)
        begin
            rd_ok_reg <= rd_ok;
        end
        if (cmd.do_put)
        begin
            out_ev_reg   <= put_kind;
            out_row_reg  <= (put_kind == EV_STORED) ? ROW_FIELD_W'(crow_reg) : '0;
            out_col_reg  <= (put_kind == EV_STORED) ? COL_FIELD_W'(ccol_reg) : '0;
            out_char_reg <= (put_kind == EV_STORED) ? char_reg : '0;
            out_crow_reg <= ROW_FIELD_W'(crow_next);
            out_ccol_reg <= COL_FIELD_W'(ccol_next);
        end
        else if (cmd.load_rd)
        begin
            out_ev_reg   <= EV_READ;
            out_row_reg  <= rrow_reg;
            out_col_reg  <= rcol_reg;
            out_char_reg <= rd_ok_reg ? mem_rdata_reg : '0;
            out_crow_reg <= ROW_FIELD_W'(crow_reg);
            out_ccol_reg <= COL_FIELD_W'(ccol_reg);
        end
    end

    assign stat.is_read     = cmd_reg;
    assign stat.is_scroll   = (put_kind == EV_SCROLLED);
    assign stat.init_last   = (init_cnt_reg == AW'(DEPTH - 1));
    assign stat.scroll_last = (scol_cnt_reg == CW'(COLS - 1));

    assign m_tdata = {out_ccol_reg, out_crow_reg, out_char_reg, out_col_reg, out_row_reg};
    assign m_tuser = out_ev_reg;

endmodule

`default_nettype wire

// File: rtl/tccb_ctrl.sv
// ----------------------------------------------------------------------------
// Text console cell buffer controller
// Sequences clearing passes, item execution and the result handshake.
// ----------------------------------------------------------------------------
`default_nettype none

module tccb_ctrl import tccb_pkg::*; (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output tccb_cmd_t       cmd,
    input  wire tccb_stat_t stat
);

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    // The result register can take a new result when empty or being drained.
    assign out_free = !out_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        s_tready       = 1'b0;
        out_valid_next = out_valid_reg && !m_tready;
        case (state_reg)
            ST_INIT_CLEAR:
            begin
                cmd.clr_init = 1'b1;
                if (stat.init_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                s_tready   = 1'b1;
                cmd.cap_in = s_tvalid;
                if (s_tvalid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (stat.is_read)
                begin
                    cmd.rd_issue = 1'b1;
                    state_next   = ST_READ_WAIT;
                end
                else if (out_free)
                begin
                    cmd.do_put     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = stat.is_scroll ? ST_SCROLL_CLEAR : ST_IDLE;
                end
            end
            ST_READ_WAIT:
            begin
                if (out_free)
                begin
                    cmd.load_rd    = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            ST_SCROLL_CLEAR:
            begin
                cmd.clr_scroll = 1'b1;
                if (stat.scroll_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_tvalid = out_valid_reg;

endmodule

`default_nettype wire

// File: rtl/text_console_cell_buffer.sv
// A put item gives its result from the put step; a read item reads the cell memory and
// loads its result in the read-wait state. A new item is accepted only once the last is done;
// after a scrolling newline the new bottom row is blanked one cell a cycle through the single cell-memory port.
// Reset: rst_n is asynchronous and active low; afterwards a clearing pass over all ROWS*COLS
// cells blanks the cell memory while s_tready stays low.
// ----------------------------------------------------------------------------
// Text console cell buffer
// Character cell store with cursor, newline handling and scrolling.
// ----------------------------------------------------------------------------
`default_nettype none

// Each accepted item is either a put (tuser low) or a read of one cell (tuser high).
// Scrolling does not move data: the datapath keeps the physical row that shows as
// the top line, so a scroll only advances that origin and blanks the row that has
// just become the bottom line. The cursor row is always beyond any previously
// written text, so every row the cursor enters is already blank.
// The result register decouples the two sides: an item is accepted while the
// previous result still waits on the master side.

module text_console_cell_buffer import tccb_pkg::*; #(
    parameter int ROWS = ROWS_DEF,
    parameter int COLS = COLS_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // char_code [7:0], read_row [12:8], read_col [19:13], zero [23:20]
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    // cmd [0]
    input  wire logic                 s_tuser,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // out_row [4:0], out_col [11:5], out_char [19:12], cursor_row_now [24:20],
    // cursor_col_now [31:25]
    output logic      [M_TDATA_W-1:0] m_tdata,
    // event_res [2:0]
    output logic      [EV_W-1:0]      m_tuser
);

    tccb_cmd_t  cmd;
    tccb_stat_t stat;

    // The controller owns both handshakes and the sequencing of each item.
    tccb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    // The datapath holds the cell memory, cursor and result register.
    tccb_datapath #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_datapath (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .cmd     (cmd),
        .stat    (stat)
    );

endmodule

`default_nettype wire

// File: rtl/tccb_checker.sv
// ----------------------------------------------------------------------------
// Text console cell buffer checker
// Port-level assertions on results and acceptance, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "text_console_cell_buffer_defines.svh"

module tccb_checker import tccb_pkg::*; (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_tvalid,
    input  wire logic                 s_tready,
    input  wire logic                 m_tvalid,
    input  wire logic                 m_tready,
    input  wire logic [M_TDATA_W-1:0] m_tdata,
    input  wire logic [EV_W-1:0]      m_tuser
);

    `TCCB_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")
    `TCCB_ASSERT_SAME(a_unused_zero, m_tvalid && (m_tuser == EV_IGNORED || m_tuser == EV_NEWLINE || m_tuser == EV_SCROLLED), m_tdata[19:0] == 20'd0, "cell fields not zero")
    `TCCB_ASSERT_SAME(a_store_cursor, m_tvalid && m_tuser == EV_STORED, m_tdata[24:20] == m_tdata[4:0] && m_tdata[31:25] == m_tdata[11:5] + 7'd1, "cursor not after stored cell")
    `TCCB_ASSERT_SAME(a_line_col, m_tvalid && (m_tuser == EV_NEWLINE || m_tuser == EV_SCROLLED), m_tdata[31:25] == 7'd0, "cursor column not zero after newline")
    `TCCB_ASSERT_NEXT(a_one_at_time, s_tvalid && s_tready, !s_tready, "item accepted while busy")

endmodule

bind text_console_cell_buffer tccb_checker u_tccb_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire
